>>> src/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, constants and helpers of the integer-to-text formatter.
// ----------------------------------------------------------------------------
package itf_pkg;

  localparam int DIGIT_BUFFER_DEF = 24;
  localparam int MAX_WIDTH_DEF    = 64;
  localparam int VALUE_W          = 64;
  localparam int FWIDTH_W         = 7;
  localparam int MDIG_W           = 5;
  localparam int CHAR_W           = 8;

  // base selector codes
  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_HEX = 2'd1;
  localparam logic [1:0] BASE_OCT = 2'd2;

  // ASCII characters
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic                is_signed;
    logic [1:0]          base_select;
    logic                upper_case;
    logic                hex_prefix;
    logic                plus_sign;
    logic                space_sign;
    logic                left_align;
    logic                zero_pad;
    logic [FWIDTH_W-1:0] field_width;
    logic [MDIG_W-1:0]   min_digits;
  } itf_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } itf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_SIZE,
    ST_EMIT
  } itf_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic dabble;
    logic scan;
    logic size;
    logic emit;
  } itf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic decimal;
    logic dabble_done;
    logic scan_done;
    logic out_free;
    logic emit_last;
  } itf_status_t;

  // map one digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base_ch;
    base_ch = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0000, d};
    end else begin
      digit_char = base_ch + {4'b0000, d} - 8'd10;
    end
  endfunction

endpackage

>>> src/itf_stream.sv
// ----------------------------------------------------------------------------
// itf_stream
// Valid/ready channel carrying one payload word of type T.
// ----------------------------------------------------------------------------
interface itf_stream #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/itf_ctrl.sv
// ----------------------------------------------------------------------------
// itf_ctrl
// Sequencer: load, binary-to-BCD conversion, leading-zero scan, layout
// sizing and character emission.
// ----------------------------------------------------------------------------
module itf_ctrl
  import itf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  itf_status_t status,
  output itf_cmd_t    cmd
);

  itf_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        // hex and octal digits are ready after load
        if (status.decimal) begin
          cmd.dabble = 1'b1;
          if (status.dabble_done) begin
            state_next = ST_SCAN;
          end
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd.size   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free && status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/itf_datapath.sv
// ----------------------------------------------------------------------------
// itf_datapath
// Digit store, double-dabble shifter, layout boundaries and the output
// word register.
// ----------------------------------------------------------------------------
module itf_datapath
  import itf_pkg::*;
#(
  parameter int DIGIT_BUFFER = DIGIT_BUFFER_DEF,
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  itf_in_t     in_word,
  input  itf_cmd_t    cmd,
  output itf_status_t status,
  input  logic        out_ready,
  output logic        out_valid,
  output itf_out_t    out_word
);

  localparam int IDX_W  = $clog2(DIGIT_BUFFER);
  localparam int ND_W   = $clog2(DIGIT_BUFFER + 1);
  localparam int STEP_W = $clog2(VALUE_W);
  localparam int POS_A  = $clog2(MAX_WIDTH + DIGIT_BUFFER + 3);
  localparam int POS_W  = (POS_A > FWIDTH_W) ? POS_A : FWIDTH_W;

  // digit store, least significant first
  logic [3:0]         dig [DIGIT_BUFFER];
  logic [VALUE_W-1:0] bin;
  logic [STEP_W-1:0]  step;
  logic               decimal;

  // captured spec
  logic              upper;
  logic              left;
  logic              zero;
  logic [POS_W-1:0]  fwidth;
  logic [ND_W-1:0]   mind;
  logic [1:0]        plen;
  logic [CHAR_W-1:0] pre0;
  logic [CHAR_W-1:0] pre1;

  // scan and layout
  logic [IDX_W-1:0] sidx;
  logic [ND_W-1:0]  nd;
  logic [POS_W-1:0] b1, b2, b3, b4, n;
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] didx;

  // ---------------- load decode ----------------
  logic                     neg;
  logic [VALUE_W-1:0]       mag;
  logic                     in_dec;
  logic [4*DIGIT_BUFFER-1:0] hex_vec;
  logic [3*DIGIT_BUFFER-1:0] oct_vec;
  logic [POS_W-1:0]         fw_ext;
  logic [ND_W:0]            md_ext;

  assign neg     = in_word.is_signed & in_word.value[VALUE_W-1];
  assign mag     = neg ? (~in_word.value + 1'b1) : in_word.value;
  assign in_dec  = in_word.is_signed ||
                   ((in_word.base_select != BASE_HEX) && (in_word.base_select != BASE_OCT));
  assign hex_vec = {{(4*DIGIT_BUFFER-VALUE_W){1'b0}}, mag};
  assign oct_vec = {{(3*DIGIT_BUFFER-VALUE_W){1'b0}}, mag};
  assign fw_ext  = POS_W'(in_word.field_width);
  assign md_ext  = (ND_W+1)'(in_word.min_digits);

  // ---------------- double dabble step ----------------
  logic [3:0] adj [DIGIT_BUFFER];
  always_comb begin
    for (int i = 0; i < DIGIT_BUFFER; i++) begin
      adj[i] = (dig[i] >= 4'd5) ? (dig[i] + 4'd3) : dig[i];
    end
  end

  // ---------------- scan result ----------------
  logic [ND_W-1:0] sig;
  assign sig = ND_W'(sidx) + 1'b1;

  // ---------------- layout sizing ----------------
  logic [POS_W-1:0] total, padn, lead, zfill, trail;
  logic [POS_W-1:0] s_b2, s_b3, s_b4;
  always_comb begin
    total = POS_W'(plen) + POS_W'(nd);
    padn  = (fwidth > total) ? (fwidth - total) : '0;
    lead  = (!left && !zero) ? padn : '0;
    zfill = (!left && zero) ? padn : '0;
    trail = left ? padn : '0;
    s_b2  = lead + POS_W'(plen);
    s_b3  = s_b2 + zfill;
    s_b4  = s_b3 + POS_W'(nd);
  end

  // ---------------- character select ----------------
  logic [CHAR_W-1:0] ch;
  logic              in_digits;
  always_comb begin
    in_digits = (pos >= b3) && (pos < b4);
    if (pos < b1) begin
      ch = CH_SPACE;
    end else if (pos < b2) begin
      ch = (pos == b1) ? pre0 : pre1;
    end else if (pos < b3) begin
      ch = CH_ZERO;
    end else if (in_digits) begin
      ch = digit_char(dig[didx], upper);
    end else begin
      ch = CH_SPACE;
    end
  end

  // load the spec, convert, scan, size, advance position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin     <= mag;
      step    <= '0;
      decimal <= in_dec;
      sidx    <= IDX_W'(DIGIT_BUFFER - 1);
      upper   <= in_word.upper_case;
      left    <= in_word.left_align;
      zero    <= in_word.zero_pad;
      fwidth  <= (fw_ext > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : fw_ext;
      mind    <= (md_ext > (ND_W+1)'(DIGIT_BUFFER)) ? ND_W'(DIGIT_BUFFER) : ND_W'(md_ext);
      pre1    <= CH_X;
      if (in_word.is_signed) begin
        pre0 <= neg ? CH_MINUS : (in_word.plus_sign ? CH_PLUS : CH_SPACE);
        plen <= (neg || in_word.plus_sign || in_word.space_sign) ? 2'd1 : 2'd0;
      end else begin
        pre0 <= CH_ZERO;
        plen <= ((in_word.base_select == BASE_HEX) && in_word.hex_prefix) ? 2'd2 : 2'd0;
      end
      for (int i = 0; i < DIGIT_BUFFER; i++) begin
        if (in_dec) begin
          dig[i] <= '0;
        end else if (in_word.base_select == BASE_HEX) begin
          dig[i] <= hex_vec[4*i +: 4];
        end else begin
          dig[i] <= {1'b0, oct_vec[3*i +: 3]};
        end
      end
    end else if (cmd.dabble) begin
      // adjust then shift one bit in from the binary word
      dig[0] <= {adj[0][2:0], bin[VALUE_W-1]};
      for (int i = 1; i < DIGIT_BUFFER; i++) begin
        dig[i] <= {adj[i][2:0], adj[i-1][3]};
      end
      bin  <= bin << 1;
      step <= step + 1'b1;
    end
    if (cmd.scan) begin
      if (status.scan_done) begin
        nd <= (sig > mind) ? sig : mind;
      end else begin
        sidx <= sidx - 1'b1;
      end
    end
    if (cmd.size) begin
      b1   <= lead;
      b2   <= s_b2;
      b3   <= s_b3;
      b4   <= s_b4;
      n    <= s_b4 + trail;
      pos  <= '0;
      didx <= IDX_W'(nd - 1'b1);
    end
    if (cmd.emit) begin
      pos <= pos + 1'b1;
      if (in_digits && (didx != '0)) begin
        didx <= didx - 1'b1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word.out_char <= ch;
      out_word.last     <= status.emit_last;
    end
  end

  // status back to the controller
  always_comb begin
    status.decimal     = decimal;
    status.dabble_done = (step == STEP_W'(VALUE_W - 1));
    status.scan_done   = (dig[sidx] != 4'd0) || (sidx == '0);
    status.out_free    = !out_valid || out_ready;
    status.emit_last   = (pos == (n - 1'b1));
  end

endmodule

>>> src/integer_to_text_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_text_formatter
// printf-style integer conversion: one 64-bit number in, its text out one
// character per word, the final character flagged with last.
// ----------------------------------------------------------------------------
// One number is handled at a time; number.ready is high only while the block
// waits for a number. Decimal numbers go through a load, a double-dabble
// shift of every bit of the 64-bit value, a leading-zero scan down from the
// top digit, a sizing step and then the emission of each character; hex and
// octal have their digits from the load and skip the shift loop. Characters
// leave the output register one per cycle while the text sink is ready. The
// last character may wait in the output register while the next number is
// taken in.
module integer_to_text_formatter
  import itf_pkg::*;
#(
  parameter int DIGIT_BUFFER = DIGIT_BUFFER_DEF,
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF
)
(
  input  logic       clk,
  input  logic       rst,
  itf_stream.sink    number,
  itf_stream.source  text
);

  itf_cmd_t    cmd;
  itf_status_t status;

  assign number.ready = cmd.accept;

  itf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (number.valid),
    .status   (status),
    .cmd      (cmd)
  );

  itf_datapath #(
    .DIGIT_BUFFER (DIGIT_BUFFER),
    .MAX_WIDTH    (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (number.data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (text.ready),
    .out_valid (text.valid),
    .out_word  (text.data)
  );

`ifndef SYNTH
  // a new word never overwrites one still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!text.valid || text.ready))
    else $error("output word overwritten");

  // a load only happens on an accepted number
  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (number.valid && number.ready))
    else $error("load without accepted number");

  // one number at a time: busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (number.valid && number.ready) |=> !number.ready)
    else $error("second number accepted while busy");

  // emission never runs together with conversion work
  a_emit_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(cmd.load || cmd.dabble || cmd.scan || cmd.size))
    else $error("emit overlaps conversion");
`endif

endmodule
